// ===== design/bmw_pkg.sv =====
package bmw_pkg;

   // Default sizes of the line store and the window.
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_RADIUS = 7;

   // Register widths and the width of the configuration data bus.
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 11;
   localparam int RADIUS_REG_W = 3;
   localparam int CFG_DATA_W   = 11;

   // Register values after reset.
   localparam logic [WIDTH_REG_W-1:0]  RST_WIDTH  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] RST_HEIGHT = 11'd480;
   localparam logic [RADIUS_REG_W-1:0] RST_RADIUS = 3'd1;

   // Entries of the result queue; a power of two.
   localparam int OUT_DEPTH = 4;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_RADIUS = 2'd2,
      CSR_MODE   = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_AND = 1'b0,
      MODE_OR  = 1'b1
   } op_mode_type;

   // Control of the window stage for one item.
   typedef struct packed {
      logic shift;
      logic emit;
      logic frame_end;
   } win_ctrl_type;

endpackage

// ===== design/bmw_req_if.sv =====
interface bmw_req_if;
   logic valid;
   logic ready;
   logic pixel_in;
   logic pad_tick;

   modport source (output valid, output pixel_in, output pad_tick, input ready);
   modport sink (input valid, input pixel_in, input pad_tick, output ready);
endinterface

// ===== design/bmw_rsp_if.sv =====
interface bmw_rsp_if;
   logic valid;
   logic ready;
   logic pixel_out;
   logic frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== design/bmw_ram.sv =====
module bmw_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bmw_window.sv =====
module bmw_window #(
   parameter int MAX_RADIUS = bmw_pkg::DEF_MAX_RADIUS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bmw_pkg::win_ctrl_type      ctrl,
   input  logic [2*MAX_RADIUS:0]      column,
   input  logic [2*MAX_RADIUS:0]      row_mask,
   input  logic [2*MAX_RADIUS:0]      col_mask,
   input  bmw_pkg::op_mode_type       op_mode,
   output logic                       out_valid,
   output logic                       out_pixel,
   output logic                       out_frame_end
);
   import bmw_pkg::*;

   localparam int WIN = 2 * MAX_RADIUS + 1;

   logic [WIN-1:0] win_ff [WIN];
   logic           emit_ff;
   logic           fend_ff;
   logic [WIN-1:0] rmask_ff;
   logic [WIN-1:0] cmask_ff;
   logic [WIN-1:0] col_all;
   logic [WIN-1:0] col_any;

   // Column shift register: entry 0 is the newest column, entry j the one j items back.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '{default: '0};
      end else if (ctrl.shift) begin
         win_ff[0] <= column;
         for (int j = 1; j < WIN; j++) begin
            win_ff[j] <= win_ff[j-1];
         end
      end
   end

   // Masks travel one stage with the item so they line up with the shifted window.
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
      end else begin
         emit_ff <= ctrl.emit;
      end
      fend_ff  <= ctrl.frame_end;
      rmask_ff <= row_mask;
      cmask_ff <= col_mask;
   end

   // Reduce each column under the row mask; columns outside the image drop out.
   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         col_all[j] = (&(win_ff[j] | ~rmask_ff)) | ~cmask_ff[j];
         col_any[j] = (|(win_ff[j] & rmask_ff)) & cmask_ff[j];
      end
   end

   assign out_valid     = emit_ff;
   assign out_pixel     = (op_mode == MODE_OR) ? (|col_any) : (&col_all);
   assign out_frame_end = fend_ff;

endmodule

// ===== design/binary_morphology_window.sv =====
// Binary dilation and erosion over a square window of side 2*radius+1.
// The req channel carries one pixel per item in raster order (1 white, 0 black);
// an item with pad_tick set carries no pixel and, once the whole frame is in,
// only pushes the remaining results out. A pad item during the frame is dropped.
// The rsp channel carries one result pixel per item, with frame_end on the last
// pixel of the frame. The result for a pixel belongs to the item that arrives
// radius rows plus radius pixels after it; that item takes it through the column store
// and window stages into the result queue, which feeds rsp. One item is accepted per
// cycle while req holds ready; the column store, read at one address and written at one
// address each cycle, keeps pace. Mode 0 gives the AND over the window, mode 1 the OR.
// The csr port writes width, height, radius and mode; every write restarts the
// frame. Reset restores 640 x 480, radius 1, mode 0 and clears all counters.
// The line store needs no clearing: rows not yet written in a frame are masked.
// When rsp stalls, results collect in a four-entry queue and req drops ready
// once every queue slot is reserved by an item in flight.
module binary_morphology_window #(
   parameter int MAX_WIDTH  = bmw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bmw_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = bmw_pkg::DEF_MAX_RADIUS
) (
   input  logic                            clock,
   input  logic                            reset,
   bmw_req_if.sink                         req_if,
   bmw_rsp_if.source                       rsp_if,
   input  logic                            csr_wr_en,
   input  bmw_pkg::csr_index_type          csr_index,
   input  logic [bmw_pkg::CFG_DATA_W-1:0]  csr_wr_data
);
   import bmw_pkg::*;

   localparam int WIN    = 2 * MAX_RADIUS + 1;
   localparam int MEM_W  = 2 * MAX_RADIUS;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
   localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
   localparam int OROW_W = $clog2(MAX_HEIGHT);
   localparam int IROW_W = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1);
   localparam int R_W    = $clog2(MAX_RADIUS + 1);
   localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                  + MAX_RADIUS + 1);
   localparam int CRD_W  = $clog2(OUT_DEPTH + 1);
   localparam int PTR_W  = $clog2(OUT_DEPTH);

   // Configuration registers.
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [RADIUS_REG_W-1:0] radius_ff;
   op_mode_type             mode_ff;

   // Effective sizes after clamping.
   logic [WEFF_W-1:0] w_eff;
   logic [HEFF_W-1:0] h_eff;
   logic [R_W-1:0]    r_eff;
   logic [COL_W-1:0]  w_last;
   logic [OROW_W-1:0] h_last;
   logic [POS_W-1:0]  lag;

   // Position counters.
   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [IROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;
   logic [POS_W-1:0]  pos_ff,     pos_in;

   // Item decode in the accept cycle.
   logic           req_acc;
   logic           pix_valid;
   logic           proc;
   logic           emit_a;
   logic           fend_a;
   logic [WIN-1:0] row_mask;
   logic [WIN-1:0] col_mask;

   // Column store stage.
   logic             b_valid_ff;
   logic             b_emit_ff;
   logic             b_fend_ff;
   logic             b_pix_ff;
   logic [COL_W-1:0] b_addr_ff;
   logic [WIN-1:0]   b_rmask_ff;
   logic [WIN-1:0]   b_cmask_ff;
   logic [MEM_W-1:0] ram_rdata;
   logic [MEM_W-1:0] rd_word;
   logic [WIN-1:0]   col_vec;
   logic             fwd_ff;
   logic [MEM_W-1:0] fwd_data_ff;
   win_ctrl_type     win_ctrl;

   // Window results and output queue.
   logic             win_valid;
   logic             win_pixel;
   logic             win_fend;
   logic             fifo_pix_ff  [OUT_DEPTH];
   logic             fifo_fend_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CRD_W-1:0] fifo_cnt_ff;
   logic [CRD_W-1:0] crd_ff;
   logic             rsp_pop;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         radius_ff <= RST_RADIUS;
         mode_ff   <= MODE_AND;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wr_data[WIDTH_REG_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wr_data[HEIGHT_REG_W-1:0];
            CSR_RADIUS: radius_ff <= csr_wr_data[RADIUS_REG_W-1:0];
            CSR_MODE:   mode_ff   <= op_mode_type'(csr_wr_data[0]);
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   // Clamp the registers to the supported range.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WEFF_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WEFF_W'(MAX_WIDTH);
      end else begin
         w_eff = WEFF_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HEFF_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HEFF_W'(MAX_HEIGHT);
      end else begin
         h_eff = HEFF_W'(height_ff);
      end
      if (32'(radius_ff) > MAX_RADIUS) begin
         r_eff = R_W'(MAX_RADIUS);
      end else begin
         r_eff = R_W'(radius_ff);
      end
   end

   assign w_last = COL_W'(w_eff - WEFF_W'(1));
   assign h_last = OROW_W'(h_eff - HEFF_W'(1));
   assign lag    = POS_W'(r_eff) * POS_W'(w_eff) + POS_W'(r_eff);

   // Decode the item at the head of req.
   assign req_acc   = req_if.valid && req_if.ready;
   assign pix_valid = (32'(in_row_ff) < 32'(h_eff));
   assign proc      = req_acc && !(pix_valid && req_if.pad_tick);
   assign emit_a    = (pos_ff >= lag);
   assign fend_a    = (out_row_ff == h_last) && (out_col_ff == w_last);

   // Window clipping: row bit k is image row out_row+R-k, column entry j is out_col+R-j.
   always_comb begin
      int r_i;
      int orow_i;
      int ocol_i;
      int h_i;
      int w_i;
      r_i    = int'(r_eff);
      orow_i = int'(out_row_ff);
      ocol_i = int'(out_col_ff);
      h_i    = int'(h_eff);
      w_i    = int'(w_eff);
      for (int k = 0; k < WIN; k++) begin
         row_mask[k] = (k <= 2 * r_i) && (orow_i + r_i - k >= 0)
                       && (orow_i + r_i - k < h_i);
         col_mask[k] = (k <= 2 * r_i) && (ocol_i + r_i - k >= 0)
                       && (ocol_i + r_i - k < w_i);
      end
   end

   // Position counters: a configuration write or the last result restarts the frame.
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pos_in     = pos_ff;
      if (csr_wr_en || (proc && emit_a && fend_a)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         pos_in     = '0;
      end else if (proc) begin
         if (emit_a) begin
            if (out_col_ff == w_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
         if (in_col_ff == w_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pos_ff     <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pos_ff     <= pos_in;
      end
   end

   // Carry the item into the column store stage while its column is read.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= proc;
      end
      b_emit_ff  <= emit_a;
      b_fend_ff  <= fend_a;
      b_pix_ff   <= pix_valid & req_if.pixel_in;
      b_addr_ff  <= in_col_ff;
      b_rmask_ff <= row_mask;
      b_cmask_ff <= col_mask;
   end

   // Each column address holds the last rows of that column, newest in bit 0.
   bmw_ram #(
      .WIDTH (MEM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data (col_vec[MEM_W-1:0]),
      .rd_addr (in_col_ff),
      .rd_data (ram_rdata)
   );

   // A read that meets a write to the same address takes the written word.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= b_valid_ff && (b_addr_ff == in_col_ff);
      end
      fwd_data_ff <= col_vec[MEM_W-1:0];
   end

   assign rd_word = fwd_ff ? fwd_data_ff : ram_rdata;
   assign col_vec = {rd_word, b_pix_ff};

   assign win_ctrl.shift     = b_valid_ff;
   assign win_ctrl.emit      = b_valid_ff && b_emit_ff;
   assign win_ctrl.frame_end = b_fend_ff;

   bmw_window #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (win_ctrl),
      .column        (col_vec),
      .row_mask      (b_rmask_ff),
      .col_mask      (b_cmask_ff),
      .op_mode       (mode_ff),
      .out_valid     (win_valid),
      .out_pixel     (win_pixel),
      .out_frame_end (win_fend)
   );

   // Result queue; a slot is reserved when an item that produces a result is accepted.
   assign rsp_pop = rsp_if.valid && rsp_if.ready;

   always_ff @(posedge clock) begin
      if (win_valid) begin
         fifo_pix_ff[wr_ptr_ff]  <= win_pixel;
         fifo_fend_ff[wr_ptr_ff] <= win_fend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         crd_ff      <= '0;
      end else begin
         if (win_valid) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + CRD_W'(win_valid) - CRD_W'(rsp_pop);
         crd_ff      <= crd_ff + CRD_W'(proc && emit_a) - CRD_W'(rsp_pop);
      end
   end

   assign req_if.ready     = (32'(crd_ff) < OUT_DEPTH);
   assign rsp_if.valid     = (fifo_cnt_ff != '0);
   assign rsp_if.pixel_out = fifo_pix_ff[rd_ptr_ff];
   assign rsp_if.frame_end = fifo_fend_ff[rd_ptr_ff];

   // The queue never holds more than the slots reserved for it.
   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= crd_ff)
      else $error("result queue holds more items than were reserved");

   // An item that owes a result passes the column store and window stages to win_valid.
   a_emit_reaches_window: assert property (@(posedge clock) disable iff (reset)
      (proc && emit_a) |-> ##2 win_valid)
      else $error("result lost between accept and window stage");

   // A result is only produced for a pixel inside the image.
   a_out_inside_image: assert property (@(posedge clock) disable iff (reset)
      (proc && emit_a) |-> ((out_row_ff <= h_last) && (out_col_ff <= w_last)))
      else $error("output position outside the image");

endmodule
